FILE: rtl/pbrf_pkg.sv
package pbrf_pkg;

    // fixed field widths
    localparam int X_W       = 32;   // interval ends and evaluation point, Q12.20
    localparam int COEF_W    = 16;
    localparam int TOL_W     = 31;
    localparam int ITER_W    = 7;
    localparam int VAL_W     = 64;   // reported polynomial value
    localparam int ACC_W     = 72;   // horner accumulator
    localparam int PART_W    = 33;   // one signed slice of the accumulator
    localparam int PROD_W    = PART_W + X_W;
    localparam int SUM_W     = ACC_W + X_W;
    localparam int NUM_COEF  = 4;

    localparam int S_DATA_W  = 2 * X_W;
    localparam int M_FIELD_W = ITER_W + 2 * X_W + VAL_W;
    localparam int M_DATA_W  = ((M_FIELD_W + 7) / 8) * 8;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd4;
    localparam logic [TOL_W-1:0]     TOL_RESET     = 31'd10;

    // accumulator slice select for the shared multiplier
    localparam logic [1:0] PART_LO  = 2'd0;
    localparam logic [1:0] PART_MID = 2'd1;
    localparam logic [1:0] PART_HI  = 2'd2;

    localparam int COEF_SEL_W = 3;

    typedef struct packed {
        logic                  load;
        logic                  init_acc;
        logic                  mul_en;
        logic [1:0]            mul_sel;
        logic                  acc_en;
        logic                  acc_first;
        logic                  fin_en;
        logic [COEF_SEL_W-1:0] coef_sel;
        logic                  low_sign_en;
        logic                  mid_en;
        logic                  upd_en;
    } pbrf_cmd_t;

    typedef struct packed {
        logic run_done;
        logic out_free;
    } pbrf_status_t;

endpackage

FILE: rtl/polynomial_bisection_root_finder.sv
// Bisection root finder for a polynomial of up to third degree with signed 16-bit integer
// coefficients (cfg registers 0..3), an unsigned Q11.20 stop tolerance (cfg register 4).
// Each input beat carries a starting interval; the block then emits one result beat per
// bisection iteration with the iteration number, the new interval ends, f(midpoint)
// clamped to signed Q44.20, and tlast on the final one. A run ends once half the interval
// width is at most the tolerance, or at MAX_ITERATIONS. One item is worked on at a time:
// f(low) is evaluated once, then each iteration forms the midpoint and evaluates it by
// Horner on a single 33x32 multiplier, three slices per Horner step. A run is held while
// the result side stalls. A finished result waits in an output register, so a new item
// can be taken while the last result of the previous run is still pending. The user must
// write configuration only while idle; the block itself does not enforce it.
module polynomial_bisection_root_finder
    import pbrf_pkg::*;
#(
    parameter int DEGREE         = 3,
    parameter int MAX_ITERATIONS = 64,
    parameter int FRACTION_BITS  = 20
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TOL_W-1:0]     cfg_wdata,
    // input beats
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // start_low, start_high
    // result beats
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // iteration, interval_low, interval_high,
                                            // midpoint_value, zero pad
    output logic                 m_tlast    // last
);

    pbrf_cmd_t    cmd;
    pbrf_status_t status;

    // sequencer: iteration and horner step control
    pbrf_ctrl #(
        .DEGREE (DEGREE)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: registers, shared multiplier, interval update, output register
    pbrf_datapath #(
        .MAX_ITERATIONS (MAX_ITERATIONS),
        .FRACTION_BITS  (FRACTION_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: rtl/pbrf_ctrl.sv
module pbrf_ctrl
    import pbrf_pkg::*;
#(
    parameter int DEGREE = 3
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  pbrf_status_t status,
    output pbrf_cmd_t    cmd
);

    localparam int IDX_W = $clog2(DEGREE + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_MID  = 3'd4;
    localparam logic [2:0] S_UPD  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [1:0]       part_reg, part_next;
    logic [IDX_W-1:0] step_reg, step_next;
    logic             eval_low_reg, eval_low_next;

    always_comb begin
        state_next    = state_reg;
        part_next     = part_reg;
        step_next     = step_reg;
        eval_low_next = eval_low_reg;
        cmd           = '0;
        s_tready      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load      = 1'b1;
                    cmd.init_acc  = 1'b1;
                    cmd.coef_sel  = COEF_SEL_W'(DEGREE);
                    eval_low_next = 1'b1;
                    part_next     = PART_HI;
                    step_next     = IDX_W'(DEGREE - 1);
                    state_next    = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = part_reg;
                // previous slice product is folded in while the next one multiplies
                if (part_reg != PART_HI) begin
                    cmd.acc_en    = 1'b1;
                    cmd.acc_first = (part_reg == PART_MID);
                end
                if (part_reg == PART_LO) begin
                    state_next = S_ACC;
                end else begin
                    part_next = part_reg - 2'd1;
                end
            end
            S_ACC: begin
                cmd.acc_en = 1'b1;
                state_next = S_FIN;
            end
            S_FIN: begin
                cmd.fin_en   = 1'b1;
                cmd.coef_sel = COEF_SEL_W'(step_reg);
                if (step_reg == '0) begin
                    state_next = eval_low_reg ? S_MID : S_UPD;
                end else begin
                    step_next  = step_reg - IDX_W'(1);
                    part_next  = PART_HI;
                    state_next = S_MUL;
                end
            end
            S_MID: begin
                cmd.mid_en      = 1'b1;
                cmd.low_sign_en = eval_low_reg;
                cmd.init_acc    = 1'b1;
                cmd.coef_sel    = COEF_SEL_W'(DEGREE);
                eval_low_next   = 1'b0;
                part_next       = PART_HI;
                step_next       = IDX_W'(DEGREE - 1);
                state_next      = S_MUL;
            end
            S_UPD: begin
                if (status.out_free) begin
                    cmd.upd_en = 1'b1;
                    state_next = status.run_done ? S_IDLE : S_MID;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            part_reg     <= PART_HI;
            step_reg     <= '0;
            eval_low_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            part_reg     <= part_next;
            step_reg     <= step_next;
            eval_low_reg <= eval_low_next;
        end
    end

endmodule

FILE: rtl/pbrf_datapath.sv
module pbrf_datapath
    import pbrf_pkg::*;
#(
    parameter int MAX_ITERATIONS = 64,
    parameter int FRACTION_BITS  = 20
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pbrf_cmd_t            cmd,
    output pbrf_status_t         status,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TOL_W-1:0]     cfg_wdata,
    input  logic [S_DATA_W-1:0]  s_tdata,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [M_DATA_W-1:0]  m_tdata,
    output logic                 m_tlast
);

    logic signed [COEF_W-1:0] coef_reg [NUM_COEF];
    logic [TOL_W-1:0]         tol_reg;

    logic signed [X_W-1:0]    low_reg, high_reg, x_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     low_neg_reg, low_zero_reg;
    logic [ITER_W-1:0]        iter_reg;

    logic                     out_valid_reg;
    logic [ITER_W-1:0]        out_iter_reg;
    logic [X_W-1:0]           out_low_reg, out_high_reg;
    logic [VAL_W-1:0]         out_val_reg;
    logic                     out_last_reg;

    // coefficient term, zero above the cubic
    logic signed [COEF_W-1:0] coef_sel_val;
    logic signed [ACC_W-1:0]  init_val;
    logic signed [SUM_W-1:0]  term_w;

    always_comb begin
        coef_sel_val = '0;
        if (cmd.coef_sel < COEF_SEL_W'(NUM_COEF)) begin
            coef_sel_val = coef_reg[cmd.coef_sel[1:0]];
        end
        init_val = ACC_W'(coef_sel_val) <<< FRACTION_BITS;
        term_w   = SUM_W'(coef_sel_val) <<< FRACTION_BITS;
    end

    // one 33 x 32 signed slice product per cycle
    logic signed [PART_W-1:0] part_val;
    always_comb begin
        case (cmd.mul_sel)
            PART_LO:  part_val = $signed({1'b0, acc_reg[31:0]});
            PART_MID: part_val = $signed({1'b0, acc_reg[63:32]});
            PART_HI:  part_val = PART_W'($signed(acc_reg[ACC_W-1:64]));
            default:  part_val = '0;
        endcase
    end

    logic signed [SUM_W-1:0] sum_next;
    assign sum_next = cmd.acc_first ? SUM_W'(prod_reg)
                                    : (sum_reg <<< X_W) + SUM_W'(prod_reg);

    // rescale, add coefficient, clamp to the accumulator range
    logic signed [SUM_W-1:0] fin_sum;
    logic signed [ACC_W-1:0] fin_val;
    logic                    fin_in_range;
    always_comb begin
        fin_sum      = (sum_reg >>> FRACTION_BITS) + term_w;
        fin_in_range = (&fin_sum[SUM_W-1:ACC_W-1]) || !(|fin_sum[SUM_W-1:ACC_W-1]);
        if (fin_in_range) begin
            fin_val = fin_sum[ACC_W-1:0];
        end else if (fin_sum[SUM_W-1]) begin
            fin_val = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            fin_val = {1'b0, {(ACC_W-1){1'b1}}};
        end
    end

    logic signed [X_W:0] mid_sum;
    logic [X_W-1:0]      mid_val;
    assign mid_sum = X_W'(1) == 1 ? ({low_reg[X_W-1], low_reg} + {high_reg[X_W-1], high_reg})
                                  : '0;
    assign mid_val = mid_sum[X_W:1];

    // keep the half whose end values are not both strictly the same sign
    logic                fc_neg, fc_zero, take_low;
    logic signed [X_W-1:0] new_low, new_high;
    logic signed [X_W:0] width;
    logic [ITER_W-1:0]   iter_next;
    logic [VAL_W-1:0]    fc_sat;

    always_comb begin
        fc_neg    = acc_reg[ACC_W-1];
        fc_zero   = (acc_reg == '0);
        take_low  = !fc_zero && !low_zero_reg && (fc_neg == low_neg_reg);
        new_low   = take_low ? x_reg : low_reg;
        new_high  = take_low ? high_reg : x_reg;
        width     = {new_high[X_W-1], new_high} - {new_low[X_W-1], new_low};
        iter_next = iter_reg + ITER_W'(1);
        status.run_done = width[X_W] || (width[X_W-1:1] <= tol_reg)
                          || (iter_next >= ITER_W'(MAX_ITERATIONS));
        status.out_free = !out_valid_reg || m_tready;
        if ((&acc_reg[ACC_W-1:VAL_W-1]) || !(|acc_reg[ACC_W-1:VAL_W-1])) begin
            fc_sat = acc_reg[VAL_W-1:0];
        end else if (fc_neg) begin
            fc_sat = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            fc_sat = {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < NUM_COEF; n++) begin
                coef_reg[n] <= '0;
            end
            tol_reg <= TOL_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_COEF_0:    coef_reg[0] <= cfg_wdata[COEF_W-1:0];
                REG_COEF_1:    coef_reg[1] <= cfg_wdata[COEF_W-1:0];
                REG_COEF_2:    coef_reg[2] <= cfg_wdata[COEF_W-1:0];
                REG_COEF_3:    coef_reg[3] <= cfg_wdata[COEF_W-1:0];
                REG_TOLERANCE: tol_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            low_reg  <= s_tdata[X_W-1:0];
            high_reg <= s_tdata[2*X_W-1:X_W];
            x_reg    <= s_tdata[X_W-1:0];
            iter_reg <= '0;
        end
        if (cmd.init_acc) begin
            acc_reg <= init_val;
        end else if (cmd.fin_en) begin
            acc_reg <= fin_val;
        end
        if (cmd.mul_en) begin
            prod_reg <= part_val * x_reg;
        end
        if (cmd.acc_en) begin
            sum_reg <= sum_next;
        end
        if (cmd.low_sign_en) begin
            low_neg_reg  <= acc_reg[ACC_W-1];
            low_zero_reg <= (acc_reg == '0);
        end
        if (cmd.mid_en) begin
            x_reg <= mid_val;
        end
        if (cmd.upd_en) begin
            low_reg      <= new_low;
            high_reg     <= new_high;
            iter_reg     <= iter_next;
            out_iter_reg <= iter_next;
            out_low_reg  <= new_low;
            out_high_reg <= new_high;
            out_val_reg  <= fc_sat;
            out_last_reg <= status.run_done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.upd_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = M_DATA_W'({out_val_reg, out_high_reg, out_low_reg, out_iter_reg});

endmodule

FILE: rtl/pbrf_checker.sv
module pbrf_checker
    import pbrf_pkg::*;
#(
    parameter int MAX_ITERATIONS = 64
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tlast
);

    logic [ITER_W-1:0] iter;
    assign iter = m_tdata[ITER_W-1:0];

    // no result beat right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result beat changed");

    a_iter_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (iter != '0) && (iter <= ITER_W'(MAX_ITERATIONS)))
        else $error("iteration number out of range");

    // a non-final result means the run is still going
    a_busy_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready in the middle of a run");

    a_cap_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (iter == ITER_W'(MAX_ITERATIONS)) |-> m_tlast)
        else $error("iteration cap reached without last");

endmodule

bind polynomial_bisection_root_finder pbrf_checker #(
    .MAX_ITERATIONS (MAX_ITERATIONS)
) u_pbrf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
